// File: rtl/rcdm_pkg.sv
// Shared types, register codes and arithmetic constants of the differential drive mixer.
package rcdm_pkg;

    // One word of raw receiver channels.
    typedef struct packed {
        logic [11:0] raw_steer;
        logic [11:0] raw_throttle;
        logic [11:0] raw_accel;
        logic [11:0] raw_mode;
        logic [11:0] raw_intake;
    } t_in_word;

    // One word of motor and intake commands.
    typedef struct packed {
        logic        left_reverse;
        logic [6:0]  left_speed;
        logic        right_reverse;
        logic [6:0]  right_speed;
        logic [11:0] intake_pulse;
        logic        climb_active;
    } t_out_word;

    typedef enum logic [1:0] {
        CFG_DRIVE_DEADBAND = 2'd0,
        CFG_INTAKE_MIN     = 2'd1,
        CFG_INTAKE_MAX     = 2'd2,
        CFG_INTAKE_STOP    = 2'd3
    } t_cfg_idx;

    localparam int NUM_CHAN   = 5;
    localparam int STEER_IDX  = 0;
    localparam int THROT_IDX  = 1;
    localparam int ACCEL_IDX  = 2;
    localparam int MODE_IDX   = 3;
    localparam int INTAKE_IDX = 4;

    localparam logic [11:0] RAW_PRESENT_MIN  = 12'd100;
    localparam logic [12:0] RAW_LO           = 13'd1000;
    localparam logic [9:0]  CHAN_OFFSET      = 10'd100;
    localparam logic [8:0]  SWITCH_THRESHOLD = 9'd50;
    localparam logic [6:0]  SIDE_LIMIT       = 7'd127;
    localparam logic [6:0]  CLIMB_TURN_MAX   = 7'd76;
    localparam logic [5:0]  INTAKE_SNAP      = 6'd40;

    // Reciprocal constants: floor(x / d) == (x * K) >> SH over the value ranges used.
    localparam logic [15:0] RECIP5_K    = 16'd52429;
    localparam int          RECIP5_SH   = 18;
    localparam int          RECIP10_SH  = 19;
    localparam logic [18:0] RECIP100_K  = 19'd335545;
    localparam int          RECIP100_SH = 25;
    localparam logic [21:0] RECIP200_K  = 22'd2684355;
    localparam int          RECIP200_SH = 29;

    localparam logic [6:0]  DEADBAND_RST    = 7'd5;
    localparam logic [11:0] INTAKE_MIN_RST  = 12'd1000;
    localparam logic [11:0] INTAKE_MAX_RST  = 12'd2000;
    localparam logic [11:0] INTAKE_STOP_RST = 12'd1500;

endpackage

// File: rtl/rc_differential_drive_mixer.sv
// Arcade-style differential drive mixer: RC channels in, side commands and intake pulse out.
// Eight register stages (stages 1 to 7 and the output register); o_done is registered
// alongside the result word. Throughput: one word per cycle outside reset, set by the
// reciprocal and product multipliers, each of which owns a stage. busy is low outside reset.
// Reset (synchronous, i_rst_n low): flush all stage valid bits, load register defaults.
module rc_differential_drive_mixer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rcdm_pkg::t_in_word  i_item,
    output logic                o_done,
    output rcdm_pkg::t_out_word o_result,
    input  logic                i_cfg_we,
    input  rcdm_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [11:0]         i_cfg_data
);
    import rcdm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  r_db;
    logic [11:0] r_imin;
    logic [11:0] r_imax;
    logic [11:0] r_istop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db    <= DEADBAND_RST;
            r_imin  <= INTAKE_MIN_RST;
            r_imax  <= INTAKE_MAX_RST;
            r_istop <= INTAKE_STOP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DRIVE_DEADBAND: r_db    <= i_cfg_data[6:0];
                CFG_INTAKE_MIN:     r_imin  <= i_cfg_data;
                CFG_INTAKE_MAX:     r_imax  <= i_cfg_data;
                CFG_INTAKE_STOP:    r_istop <= i_cfg_data;
            endcase
        end
    end

    // No backpressure: the pipeline takes a word every cycle once out of reset.
    assign busy = !i_rst_n;

    // ------------------------------------------------------------------
    // Stage valid bits
    // ------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= start && !busy;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_out_vld <= r_s7_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: distance from 1000, magnitude times reciprocal of 5
    // (division by 10 reuses the same product with one more shift).
    // ------------------------------------------------------------------
    logic [11:0]        w_raw     [NUM_CHAN];
    logic signed [12:0] w_s0_dist [NUM_CHAN];
    logic [11:0]        w_s0_mag  [NUM_CHAN];
    logic [27:0]        n_s1_prod [NUM_CHAN];
    logic               n_s1_neg  [NUM_CHAN];
    logic               n_s1_pres [NUM_CHAN];
    logic [27:0]        r_s1_prod [NUM_CHAN];
    logic               r_s1_neg  [NUM_CHAN];
    logic               r_s1_pres [NUM_CHAN];

    assign w_raw[STEER_IDX]  = i_item.raw_steer;
    assign w_raw[THROT_IDX]  = i_item.raw_throttle;
    assign w_raw[ACCEL_IDX]  = i_item.raw_accel;
    assign w_raw[MODE_IDX]   = i_item.raw_mode;
    assign w_raw[INTAKE_IDX] = i_item.raw_intake;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_s0_dist[c] = $signed({1'b0, w_raw[c]}) - $signed(RAW_LO);
            w_s0_mag[c]  = w_s0_dist[c][12] ? 12'(-w_s0_dist[c]) : w_s0_dist[c][11:0];
            n_s1_prod[c] = 28'(w_s0_mag[c]) * 28'(RECIP5_K);
            n_s1_neg[c]  = w_s0_dist[c][12];
            n_s1_pres[c] = (w_raw[c] >= RAW_PRESENT_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            r_s1_prod[c] <= n_s1_prod[c];
            r_s1_neg[c]  <= n_s1_neg[c];
            r_s1_pres[c] <= n_s1_pres[c];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: mapped channel values as sign and magnitude.
    // Steer and intake are kept offset by +100, which is what the later
    // maps consume; an absent channel maps to 0, i.e. 100 after offset.
    // ------------------------------------------------------------------
    logic [9:0]         w_q5_steer, w_q5_throt, w_q5_intake;
    logic [8:0]         w_q10_accel, w_q10_mode;
    logic signed [11:0] w_thr;
    logic [9:0]         n_s2_stp_m, n_s2_inp_m, n_s2_thr_m;
    logic [8:0]         n_s2_acc_m;
    logic               n_s2_stp_n, n_s2_inp_n, n_s2_thr_n, n_s2_acc_n, n_s2_climb;
    logic [9:0]         r_s2_stp_m, r_s2_inp_m, r_s2_thr_m;
    logic [8:0]         r_s2_acc_m;
    logic               r_s2_stp_n, r_s2_inp_n, r_s2_thr_n, r_s2_acc_n, r_s2_climb;

    always_comb begin
        w_q5_steer  = r_s1_prod[STEER_IDX][RECIP5_SH +: 10];
        w_q5_throt  = r_s1_prod[THROT_IDX][RECIP5_SH +: 10];
        w_q5_intake = r_s1_prod[INTAKE_IDX][RECIP5_SH +: 10];
        w_q10_accel = r_s1_prod[ACCEL_IDX][RECIP10_SH +: 9];
        w_q10_mode  = r_s1_prod[MODE_IDX][RECIP10_SH +: 9];

        n_s2_stp_m = r_s1_pres[STEER_IDX] ? w_q5_steer : CHAN_OFFSET;
        n_s2_stp_n = r_s1_pres[STEER_IDX] && r_s1_neg[STEER_IDX];
        n_s2_inp_m = r_s1_pres[INTAKE_IDX] ? w_q5_intake : CHAN_OFFSET;
        n_s2_inp_n = r_s1_pres[INTAKE_IDX] && r_s1_neg[INTAKE_IDX];

        w_thr = r_s1_neg[THROT_IDX] ? -$signed({2'b0, w_q5_throt}) : $signed({2'b0, w_q5_throt});
        w_thr = w_thr - $signed({2'b0, CHAN_OFFSET});
        if (!r_s1_pres[THROT_IDX]) begin
            w_thr = '0;
        end
        n_s2_thr_n = w_thr[11];
        n_s2_thr_m = w_thr[11] ? 10'(-w_thr) : w_thr[9:0];

        n_s2_acc_m = r_s1_pres[ACCEL_IDX] ? w_q10_accel : '0;
        n_s2_acc_n = r_s1_pres[ACCEL_IDX] && r_s1_neg[ACCEL_IDX];

        n_s2_climb = r_s1_pres[MODE_IDX] && !r_s1_neg[MODE_IDX]
                     && (w_q10_mode > SWITCH_THRESHOLD);
    end

    always_ff @(posedge i_clk) begin
        r_s2_stp_m <= n_s2_stp_m;
        r_s2_stp_n <= n_s2_stp_n;
        r_s2_inp_m <= n_s2_inp_m;
        r_s2_inp_n <= n_s2_inp_n;
        r_s2_thr_m <= n_s2_thr_m;
        r_s2_thr_n <= n_s2_thr_n;
        r_s2_acc_m <= n_s2_acc_m;
        r_s2_acc_n <= n_s2_acc_n;
        r_s2_climb <= n_s2_climb;
    end

    // ------------------------------------------------------------------
    // Stage 3: first products. accel*127 (scale), |throttle|*127 (climb
    // adjust), steer*76 (climb turn), intake*(max - min) (servo span).
    // ------------------------------------------------------------------
    logic signed [12:0] w_span;
    logic [11:0]        w_span_m;
    logic [15:0]        n_s3_acc_prod, n_s3_tc_prod;
    logic [16:0]        n_s3_adj_prod;
    logic [21:0]        n_s3_in_prod;
    logic               n_s3_in_n;
    logic [15:0]        r_s3_acc_prod, r_s3_tc_prod;
    logic [16:0]        r_s3_adj_prod;
    logic [21:0]        r_s3_in_prod;
    logic               r_s3_in_n;
    logic [9:0]         r_s3_stp_m, r_s3_thr_m;
    logic               r_s3_stp_n, r_s3_thr_n, r_s3_acc_n, r_s3_climb;

    always_comb begin
        w_span        = $signed({1'b0, r_imax}) - $signed({1'b0, r_imin});
        w_span_m      = w_span[12] ? 12'(-w_span) : w_span[11:0];
        n_s3_acc_prod = 16'(r_s2_acc_m) * 16'(SIDE_LIMIT);
        n_s3_adj_prod = 17'(r_s2_thr_m) * 17'(SIDE_LIMIT);
        n_s3_tc_prod  = 16'(r_s2_stp_m) * 16'(CLIMB_TURN_MAX);
        n_s3_in_prod  = 22'(r_s2_inp_m) * 22'(w_span_m);
        n_s3_in_n     = r_s2_inp_n ^ w_span[12];
    end

    always_ff @(posedge i_clk) begin
        r_s3_acc_prod <= n_s3_acc_prod;
        r_s3_adj_prod <= n_s3_adj_prod;
        r_s3_tc_prod  <= n_s3_tc_prod;
        r_s3_in_prod  <= n_s3_in_prod;
        r_s3_in_n     <= n_s3_in_n;
        r_s3_stp_m    <= r_s2_stp_m;
        r_s3_stp_n    <= r_s2_stp_n;
        r_s3_thr_m    <= r_s2_thr_m;
        r_s3_thr_n    <= r_s2_thr_n;
        r_s3_acc_n    <= r_s2_acc_n;
        r_s3_climb    <= r_s2_climb;
    end

    // ------------------------------------------------------------------
    // Stage 4: divide the first products by 100 or 200 via reciprocals.
    // Magnitudes are divided, so the quotient truncates toward zero.
    // ------------------------------------------------------------------
    logic [34:0] w_mag_full, w_tcq_full;
    logic [35:0] w_adj_full;
    logic [43:0] w_iq_full;
    logic [8:0]  n_s4_mag_m, n_s4_tcq;
    logic [9:0]  n_s4_adj_m;
    logic [13:0] n_s4_iq;
    logic [8:0]  r_s4_mag_m, r_s4_tcq;
    logic [9:0]  r_s4_adj_m;
    logic [13:0] r_s4_iq;
    logic        r_s4_in_n;
    logic [9:0]  r_s4_stp_m, r_s4_thr_m;
    logic        r_s4_stp_n, r_s4_thr_n, r_s4_mag_n, r_s4_climb;

    always_comb begin
        w_mag_full = 35'(r_s3_acc_prod) * 35'(RECIP100_K);
        w_adj_full = 36'(r_s3_adj_prod) * 36'(RECIP100_K);
        w_tcq_full = 35'(r_s3_tc_prod) * 35'(RECIP100_K);
        w_iq_full  = 44'(r_s3_in_prod) * 44'(RECIP200_K);
        n_s4_mag_m = w_mag_full[RECIP100_SH +: 9];
        n_s4_adj_m = w_adj_full[RECIP100_SH +: 10];
        n_s4_tcq   = w_tcq_full[RECIP100_SH +: 9];
        n_s4_iq    = w_iq_full[RECIP200_SH +: 14];
    end

    always_ff @(posedge i_clk) begin
        r_s4_mag_m <= n_s4_mag_m;
        r_s4_adj_m <= n_s4_adj_m;
        r_s4_tcq   <= n_s4_tcq;
        r_s4_iq    <= n_s4_iq;
        r_s4_in_n  <= r_s3_in_n;
        r_s4_stp_m <= r_s3_stp_m;
        r_s4_stp_n <= r_s3_stp_n;
        r_s4_thr_m <= r_s3_thr_m;
        r_s4_thr_n <= r_s3_thr_n;
        r_s4_mag_n <= r_s3_acc_n;
        r_s4_climb <= r_s3_climb;
    end

    // ------------------------------------------------------------------
    // Side clamp to +/-127, shared by the climb forward term and the sides.
    // ------------------------------------------------------------------
    function automatic logic signed [7:0] clamp_side(input logic signed [14:0] v);
        logic signed [14:0] lim;
        lim = $signed(15'(SIDE_LIMIT));
        if (v > lim) begin
            clamp_side = 8'(lim);
        end else if (v < -lim) begin
            clamp_side = 8'(-lim);
        end else begin
            clamp_side = v[7:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Stage 5: normal-mode products with the scale; climb forward and
    // turn terms; raw intake pulse before clamping.
    // ------------------------------------------------------------------
    logic signed [9:0]  w_magv;
    logic signed [10:0] w_adj;
    logic signed [11:0] w_csum;
    logic [17:0]        n_s5_nf_prod, n_s5_nt_prod;
    logic signed [7:0]  n_s5_cfwd;
    logic signed [10:0] n_s5_cturn;
    logic signed [15:0] n_s5_us;
    logic [17:0]        r_s5_nf_prod, r_s5_nt_prod;
    logic               r_s5_nf_n, r_s5_nt_n, r_s5_climb;
    logic signed [9:0]  r_s5_magv;
    logic signed [7:0]  r_s5_cfwd;
    logic signed [10:0] r_s5_cturn;
    logic signed [15:0] r_s5_us;

    always_comb begin
        n_s5_nf_prod = 18'(r_s4_thr_m) * 18'(r_s4_mag_m);
        n_s5_nt_prod = 18'(r_s4_stp_m) * 18'(r_s4_mag_m);

        w_magv = r_s4_mag_n ? -$signed({1'b0, r_s4_mag_m}) : $signed({1'b0, r_s4_mag_m});
        w_adj  = r_s4_thr_n ? -$signed({1'b0, r_s4_adj_m}) : $signed({1'b0, r_s4_adj_m});
        w_csum = 12'(w_adj) + 12'(w_magv);
        n_s5_cfwd = clamp_side(15'(-w_csum));

        n_s5_cturn = (r_s4_stp_n ? -$signed({2'b0, r_s4_tcq}) : $signed({2'b0, r_s4_tcq}))
                     - $signed({4'b0, CLIMB_TURN_MAX});

        n_s5_us = (r_s4_in_n ? -$signed({2'b0, r_s4_iq}) : $signed({2'b0, r_s4_iq}))
                  + $signed({4'b0, r_imin});
    end

    always_ff @(posedge i_clk) begin
        r_s5_nf_prod <= n_s5_nf_prod;
        r_s5_nt_prod <= n_s5_nt_prod;
        r_s5_nf_n    <= r_s4_thr_n ^ r_s4_mag_n;
        r_s5_nt_n    <= r_s4_stp_n ^ r_s4_mag_n;
        r_s5_magv    <= w_magv;
        r_s5_cfwd    <= n_s5_cfwd;
        r_s5_cturn   <= n_s5_cturn;
        r_s5_us      <= n_s5_us;
        r_s5_climb   <= r_s4_climb;
    end

    // ------------------------------------------------------------------
    // Stage 6: normal-mode quotients by 100; clamp the intake pulse
    // (low limit first, so it wins for a pulse below min even when min exceeds max).
    // ------------------------------------------------------------------
    logic [36:0]        w_nf_full, w_nt_full;
    logic signed [15:0] w_imin_s, w_imax_s;
    logic [10:0]        n_s6_nf_m;
    logic [11:0]        n_s6_nt_m;
    logic [11:0]        n_s6_us;
    logic [10:0]        r_s6_nf_m;
    logic [11:0]        r_s6_nt_m;
    logic [11:0]        r_s6_us;
    logic               r_s6_nf_n, r_s6_nt_n, r_s6_climb;
    logic signed [9:0]  r_s6_magv;
    logic signed [7:0]  r_s6_cfwd;
    logic signed [10:0] r_s6_cturn;

    always_comb begin
        w_nf_full = 37'(r_s5_nf_prod) * 37'(RECIP100_K);
        w_nt_full = 37'(r_s5_nt_prod) * 37'(RECIP100_K);
        n_s6_nf_m = w_nf_full[RECIP100_SH +: 11];
        n_s6_nt_m = w_nt_full[RECIP100_SH +: 12];

        w_imin_s = $signed({4'b0, r_imin});
        w_imax_s = $signed({4'b0, r_imax});
        priority if (r_s5_us < w_imin_s) begin
            n_s6_us = r_imin;
        end else if (r_s5_us > w_imax_s) begin
            n_s6_us = r_imax;
        end else begin
            n_s6_us = r_s5_us[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_nf_m  <= n_s6_nf_m;
        r_s6_nt_m  <= n_s6_nt_m;
        r_s6_us    <= n_s6_us;
        r_s6_nf_n  <= r_s5_nf_n;
        r_s6_nt_n  <= r_s5_nt_n;
        r_s6_magv  <= r_s5_magv;
        r_s6_cfwd  <= r_s5_cfwd;
        r_s6_cturn <= r_s5_cturn;
        r_s6_climb <= r_s5_climb;
    end

    // ------------------------------------------------------------------
    // Stage 7: mix the sides for the active mode and clamp them; snap the
    // intake pulse to stop when it lies within the snap band.
    // ------------------------------------------------------------------
    logic signed [12:0] w_nfwd, w_nturn, w_idiff;
    logic [12:0]        w_idiff_m;
    logic signed [14:0] w_left, w_right;
    logic signed [7:0]  n_s7_left, n_s7_right;
    logic [11:0]        n_s7_us;
    logic signed [7:0]  r_s7_left, r_s7_right;
    logic [11:0]        r_s7_us;
    logic               r_s7_climb;

    always_comb begin
        w_nfwd  = r_s6_nf_n ? -$signed({2'b0, r_s6_nf_m}) : $signed({2'b0, r_s6_nf_m});
        w_nturn = (r_s6_nt_n ? -$signed({1'b0, r_s6_nt_m}) : $signed({1'b0, r_s6_nt_m}))
                  - 13'(r_s6_magv);
        if (r_s6_climb) begin
            w_left  = 15'(r_s6_cfwd) - 15'(r_s6_cturn);
            w_right = 15'(r_s6_cfwd) + 15'(r_s6_cturn);
        end else begin
            w_left  = 15'(w_nfwd) + 15'(w_nturn);
            w_right = 15'(w_nfwd) - 15'(w_nturn);
        end
        n_s7_left  = clamp_side(w_left);
        n_s7_right = clamp_side(w_right);

        w_idiff   = $signed({1'b0, r_s6_us}) - $signed({1'b0, r_istop});
        w_idiff_m = w_idiff[12] ? 13'(-w_idiff) : 13'(w_idiff);
        n_s7_us   = (w_idiff_m < 13'(INTAKE_SNAP)) ? r_istop : r_s6_us;
    end

    always_ff @(posedge i_clk) begin
        r_s7_left  <= n_s7_left;
        r_s7_right <= n_s7_right;
        r_s7_us    <= n_s7_us;
        r_s7_climb <= r_s6_climb;
    end

    // ------------------------------------------------------------------
    // Output stage: deadband, then direction and speed. A zeroed side
    // reports forward.
    // ------------------------------------------------------------------
    logic [6:0] w_lmag, w_rmag;
    logic       w_ldead, w_rdead;
    t_out_word  n_out;
    t_out_word  r_out;

    always_comb begin
        w_lmag  = r_s7_left[7] ? 7'(-r_s7_left) : r_s7_left[6:0];
        w_rmag  = r_s7_right[7] ? 7'(-r_s7_right) : r_s7_right[6:0];
        w_ldead = (w_lmag < r_db);
        w_rdead = (w_rmag < r_db);

        n_out.left_reverse  = r_s7_left[7] && !w_ldead;
        n_out.left_speed    = w_ldead ? '0 : w_lmag;
        n_out.right_reverse = r_s7_right[7] && !w_rdead;
        n_out.right_speed   = w_rdead ? '0 : w_rmag;
        n_out.intake_pulse  = r_s7_us;
        n_out.climb_active  = r_s7_climb;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule
